/* hdl/fjkv_pkg.sv */
package fjkv_pkg;

	localparam int unsigned MAX_KEY_BYTES = 32;
	localparam int unsigned DEPTH_BITS    = 16;
	localparam int unsigned KEY_LEN_BITS  = 6;
	localparam int unsigned KEY_REGS      = 4;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = 64;

	localparam logic [CFG_IDX_BITS-1:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_KEY_LOW    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KEY_MID    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_KEY_HIGH   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_KEY_TOP    = 3'd4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_END   = 1'b1;

	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_BITS = 2;
	localparam int unsigned QCNT_BITS = 3;

	typedef struct packed {
		logic       kind;
		logic [7:0] vbyte;
		logic       found;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} res_pair_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

/* hdl/fjkv_scan.sv */
module fjkv_scan (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [fjkv_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [fjkv_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                   item_valid,
	input  logic [7:0]                             item_byte,
	input  logic                                   item_end,
	output fjkv_pkg::res_pair_t                    res
);

	typedef enum logic [2:0] {
		M_OUT   = 3'd0,
		M_STR   = 3'd1,
		M_KEY   = 3'd2,
		M_COLON = 3'd3,
		M_VWAIT = 3'd4,
		M_VAL   = 3'd5,
		M_DONE  = 3'd6
	} mode_t;

	localparam logic [fjkv_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [fjkv_pkg::KEY_LEN_BITS-1:0] KEY_LEN_MAX =
		fjkv_pkg::KEY_LEN_BITS'(fjkv_pkg::MAX_KEY_BYTES);

	logic [fjkv_pkg::KEY_LEN_BITS-1:0]                     key_len_q;
	logic [fjkv_pkg::KEY_REGS-1:0][fjkv_pkg::CFG_DATA_BITS-1:0] key_q;

	mode_t                              mode_q, mode_n;
	logic [fjkv_pkg::DEPTH_BITS-1:0]    depth_q, depth_n;
	logic [fjkv_pkg::KEY_LEN_BITS-1:0]  pos_q, pos_n;
	logic                               esc_q, esc_n;

	logic [fjkv_pkg::KEY_LEN_BITS-1:0]  key_len;
	logic [7:0]                         key_byte;
	logic                               hit;
	logic                               outside;
	logic [7:0]                         vb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			key_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fjkv_pkg::REG_KEY_LENGTH: key_len_q <= cfg_data[fjkv_pkg::KEY_LEN_BITS-1:0];
				fjkv_pkg::REG_KEY_LOW:    key_q[0] <= cfg_data;
				fjkv_pkg::REG_KEY_MID:    key_q[1] <= cfg_data;
				fjkv_pkg::REG_KEY_HIGH:   key_q[2] <= cfg_data;
				fjkv_pkg::REG_KEY_TOP:    key_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign key_len  = (key_len_q > KEY_LEN_MAX) ? KEY_LEN_MAX : key_len_q;
	assign key_byte = key_q[pos_q[4:3]][{pos_q[2:0], 3'b000} +: 8];
	assign hit      = (pos_q < key_len) && (item_byte == key_byte);

	always_comb begin
		mode_n  = mode_q;
		depth_n = depth_q;
		pos_n   = pos_q;
		esc_n   = esc_q;
		res     = '0;
		outside = 1'b0;
		vb      = item_byte;

		unique case (mode_q)
			M_STR: begin
				if (esc_q) begin
					esc_n = 1'b0;
				end else if (item_byte == fjkv_pkg::CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (item_byte == fjkv_pkg::CH_QUOTE) begin
					mode_n = M_OUT;
				end
			end
			M_KEY: begin
				if (!esc_q && item_byte == fjkv_pkg::CH_QUOTE) begin
					mode_n = (pos_q == key_len) ? M_COLON : M_OUT;
					pos_n  = '0;
				end else begin
					if (esc_q) begin
						esc_n = 1'b0;
					end else if (item_byte == fjkv_pkg::CH_BSLASH) begin
						esc_n = 1'b1;
					end
					if (hit) begin
						pos_n = pos_q + 6'd1;
					end else begin
						mode_n = M_STR;
						pos_n  = '0;
					end
				end
			end
			M_COLON: begin
				if (!fjkv_pkg::is_space(item_byte)) begin
					if (item_byte == fjkv_pkg::CH_COLON) begin
						mode_n = M_VWAIT;
					end else begin
						mode_n  = M_OUT;
						outside = 1'b1;
					end
				end
			end
			M_VWAIT: begin
				if (!fjkv_pkg::is_space(item_byte)) begin
					if (item_byte == fjkv_pkg::CH_QUOTE) begin
						mode_n = M_VAL;
						esc_n  = 1'b0;
					end else begin
						mode_n           = M_DONE;
						res.count        = 2'd1;
						res.first.kind   = fjkv_pkg::KIND_END;
						res.first.found  = 1'b0;
					end
				end
			end
			M_VAL: begin
				if (esc_q) begin
					priority if (item_byte == fjkv_pkg::CH_N) begin
						vb = fjkv_pkg::CH_LF;
					end else if (item_byte == fjkv_pkg::CH_T) begin
						vb = fjkv_pkg::CH_TAB;
					end else if (item_byte == fjkv_pkg::CH_R) begin
						vb = fjkv_pkg::CH_CR;
					end else begin
						vb = item_byte;
					end
					esc_n           = 1'b0;
					res.count       = 2'd1;
					res.first.kind  = fjkv_pkg::KIND_VALUE;
					res.first.vbyte = vb;
				end else if (item_byte == fjkv_pkg::CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (item_byte == fjkv_pkg::CH_QUOTE) begin
					mode_n          = M_DONE;
					res.count       = 2'd1;
					res.first.kind  = fjkv_pkg::KIND_END;
					res.first.found = 1'b1;
				end else begin
					res.count       = 2'd1;
					res.first.kind  = fjkv_pkg::KIND_VALUE;
					res.first.vbyte = item_byte;
				end
			end
			M_DONE: begin
			end
			M_OUT: begin
				outside = 1'b1;
			end
			default: begin
				mode_n  = M_OUT;
				outside = 1'b1;
			end
		endcase

		if (outside) begin
			if (item_byte == fjkv_pkg::CH_QUOTE) begin
				mode_n = (depth_q == fjkv_pkg::DEPTH_BITS'(1)) ? M_KEY : M_STR;
				pos_n  = '0;
				esc_n  = 1'b0;
			end else if (item_byte == fjkv_pkg::CH_LBRACE || item_byte == fjkv_pkg::CH_LBRACK) begin
				if (depth_q != DEPTH_MAX) begin
					depth_n = depth_q + fjkv_pkg::DEPTH_BITS'(1);
				end
			end else if (item_byte == fjkv_pkg::CH_RBRACE || item_byte == fjkv_pkg::CH_RBRACK) begin
				if (depth_q != '0) begin
					depth_n = depth_q - fjkv_pkg::DEPTH_BITS'(1);
				end
			end
		end

		if (item_end) begin
			if (mode_n != M_DONE) begin
				if (res.count == 2'd0) begin
					res.first.kind  = fjkv_pkg::KIND_END;
					res.first.found = (mode_n == M_VAL);
				end else begin
					res.second.kind  = fjkv_pkg::KIND_END;
					res.second.found = (mode_n == M_VAL);
				end
				res.count = res.count + 2'd1;
			end
			mode_n  = M_OUT;
			depth_n = '0;
			pos_n   = '0;
			esc_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_OUT;
			depth_q <= '0;
			pos_q   <= '0;
			esc_q   <= 1'b0;
		end else if (item_valid) begin
			mode_q  <= mode_n;
			depth_q <= depth_n;
			pos_q   <= pos_n;
			esc_q   <= esc_n;
		end
	end

	a_value_only_in_val: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && res.count != 2'd0 && res.first.kind == fjkv_pkg::KIND_VALUE
		|-> mode_q == M_VAL)
		else $error("value byte emitted outside a value string");

	a_pair_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && res.count == 2'd2
		|-> item_end && res.second.kind == fjkv_pkg::KIND_END
		&& res.first.kind == fjkv_pkg::KIND_VALUE)
		else $error("two results without a closing marker");

	a_end_resets_scan: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_end |=> mode_q == M_OUT && depth_q == '0 && !esc_q)
		else $error("scan state not cleared after last byte");

endmodule

/* hdl/fjkv_rq.sv */
module fjkv_rq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  fjkv_pkg::res_pair_t push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [7:0]          value_byte,
	output logic                key_found
);

	fjkv_pkg::res_t                      entry_q [fjkv_pkg::QDEPTH];
	logic [fjkv_pkg::QPTR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
	logic [fjkv_pkg::QCNT_BITS-1:0]      count_q;
	logic [1:0]                          n_push;
	logic                                pop;
	fjkv_pkg::res_t                      head;

	assign n_push    = push_en ? push.count : 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign room      = (count_q <= fjkv_pkg::QCNT_BITS'(fjkv_pkg::QDEPTH - 2));
	assign head      = entry_q[rd_ptr_q];

	assign result_kind = head.kind;
	assign value_byte  = head.vbyte;
	assign key_found   = head.found;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (n_push == 2'd2) begin
			entry_q[wr_ptr_q + fjkv_pkg::QPTR_BITS'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fjkv_pkg::QPTR_BITS'(n_push);
			rd_ptr_q <= rd_ptr_q + fjkv_pkg::QPTR_BITS'(pop);
			count_q  <= count_q + fjkv_pkg::QCNT_BITS'(n_push)
				- fjkv_pkg::QCNT_BITS'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fjkv_pkg::QCNT_BITS'(fjkv_pkg::QDEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> room)
		else $error("item pushed without room");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(head))
		else $error("stalled result changed");

endmodule

/* hdl/flat_json_key_value_extractor.sv */
// Flat JSON key/value extractor.
// Input channel (in_valid/in_stall) carries one document byte per item with
// doc_end marking the last byte. Output channel (out_valid/out_stall) carries
// result items: value bytes of the matched top-level string field
// (result_kind 0), then one end marker (result_kind 1) with key_found.
// Configuration: write key_length and the four key byte words through
// cfg_we/cfg_index/cfg_data while the block is idle; writes land at once.
// A byte accepted into the input register passes through the combinational scan
// into the result queue, whose head drives the output. Throughput: one byte per
// cycle while the queue has room; a byte that yields two results (value byte plus
// end marker on the last byte) pushes both. The rate is set by the scan and the
// four-entry result queue, which takes a new byte while it holds two or fewer.
// Reset clears the key registers, scan state, the input register and the
// queue. When the receiver stalls, results wait in the queue; once it holds
// more than two, in_stall rises and the byte in the input register holds.
module flat_json_key_value_extractor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fjkv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [fjkv_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         doc_byte,
	input  logic                               doc_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               result_kind,
	output logic [7:0]                         value_byte,
	output logic                               key_found
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                room;
	logic                consume;
	fjkv_pkg::res_pair_t res;

	assign consume  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= doc_byte;
			end_s1  <= doc_end;
		end
	end

	fjkv_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (consume),
		.item_byte  (byte_s1),
		.item_end   (end_s1),
		.res        (res)
	);

	fjkv_rq u_rq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_en     (consume),
		.push        (res),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value_byte  (value_byte),
		.key_found   (key_found)
	);

endmodule

/* sim/fjkv_checker.sv */
module fjkv_checker
	import fjkv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [7:0]               doc_byte,
	input  logic                     doc_end,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     result_kind,
	input  logic [7:0]               value_byte,
	input  logic                     key_found,
	output int                       mismatches,
	output int                       results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		SCAN_OUT,
		SCAN_STR,
		SCAN_KEY,
		SCAN_COLON,
		SCAN_VALUE_WAIT,
		SCAN_VALUE,
		SCAN_DONE
	} scan_mode_t;

	scan_mode_t               mode;
	logic [DEPTH_BITS-1:0]    depth;
	logic [KEY_LEN_BITS-1:0]  match_pos;
	logic                     escaped;
	logic [KEY_LEN_BITS-1:0]  key_len;
	logic [CFG_DATA_BITS-1:0] key_word [KEY_REGS];
	res_t                     extract_due [$];
	res_t                     want;

	function automatic logic blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [KEY_LEN_BITS-1:0] key_span();
		return (key_len > MAX_KEY_BYTES) ? KEY_LEN_BITS'(MAX_KEY_BYTES) : key_len;
	endfunction

	task automatic emit_result(input logic kind, input logic [7:0] vb, input logic found);
		res_t r;
		r.kind  = kind;
		r.vbyte = vb;
		r.found = found;
		extract_due.insert(extract_due.size(), r);
	endtask

	task automatic track_nesting(input logic [7:0] c);
		if (c == CH_QUOTE) begin
			mode      = (depth == 1) ? SCAN_KEY : SCAN_STR;
			match_pos = '0;
			escaped   = 1'b0;
		end else if (c == CH_LBRACE || c == CH_LBRACK) begin
			if (depth != '1)
				depth = depth + 1'b1;
		end else if (c == CH_RBRACE || c == CH_RBRACK) begin
			if (depth != '0)
				depth = depth - 1'b1;
		end
	endtask

	task automatic extract_step(input logic [7:0] c, input logic last);
		logic       hit;
		logic [7:0] v;
		case (mode)
			SCAN_STR: begin
				if (escaped)
					escaped = 1'b0;
				else if (c == CH_BSLASH)
					escaped = 1'b1;
				else if (c == CH_QUOTE)
					mode = SCAN_OUT;
			end
			SCAN_KEY: begin
				if (!escaped && c == CH_QUOTE) begin
					mode      = (match_pos == key_span()) ? SCAN_COLON : SCAN_OUT;
					match_pos = '0;
				end else begin
					hit = (match_pos < key_span()) &&
						(c == key_word[match_pos[4:3]][match_pos[2:0]*8 +: 8]);
					if (escaped)
						escaped = 1'b0;
					else if (c == CH_BSLASH)
						escaped = 1'b1;
					if (hit) begin
						match_pos = match_pos + 1'b1;
					end else begin
						mode      = SCAN_STR;
						match_pos = '0;
					end
				end
			end
			SCAN_COLON: begin
				if (!blank(c)) begin
					if (c == CH_COLON) begin
						mode = SCAN_VALUE_WAIT;
					end else begin
						mode = SCAN_OUT;
						track_nesting(c);
					end
				end
			end
			SCAN_VALUE_WAIT: begin
				if (!blank(c)) begin
					if (c == CH_QUOTE) begin
						mode    = SCAN_VALUE;
						escaped = 1'b0;
					end else begin
						mode = SCAN_DONE;
						emit_result(KIND_END, 8'h00, 1'b0);
					end
				end
			end
			SCAN_VALUE: begin
				if (escaped) begin
					if (c == CH_N)
						v = CH_LF;
					else if (c == CH_T)
						v = CH_TAB;
					else if (c == CH_R)
						v = CH_CR;
					else
						v = c;
					escaped = 1'b0;
					emit_result(KIND_VALUE, v, 1'b0);
				end else if (c == CH_BSLASH) begin
					escaped = 1'b1;
				end else if (c == CH_QUOTE) begin
					mode = SCAN_DONE;
					emit_result(KIND_END, 8'h00, 1'b1);
				end else begin
					emit_result(KIND_VALUE, c, 1'b0);
				end
			end
			SCAN_DONE: ;
			default: begin
				mode = SCAN_OUT;
				track_nesting(c);
			end
		endcase
		if (last) begin
			if (mode != SCAN_DONE)
				emit_result(KIND_END, 8'h00, mode == SCAN_VALUE);
			mode      = SCAN_OUT;
			depth     = '0;
			match_pos = '0;
			escaped   = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode      = SCAN_OUT;
			depth     = '0;
			match_pos = '0;
			escaped   = 1'b0;
			key_len   = '0;
			foreach (key_word[i])
				key_word[i] = '0;
			extract_due.delete();
			mismatches = 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LENGTH: key_len = cfg_data[KEY_LEN_BITS-1:0];
					REG_KEY_LOW:    key_word[0] = cfg_data;
					REG_KEY_MID:    key_word[1] = cfg_data;
					REG_KEY_HIGH:   key_word[2] = cfg_data;
					REG_KEY_TOP:    key_word[3] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				extract_step(doc_byte, doc_end);
			if (out_valid && !out_stall) begin
				if (extract_due.size() == 0) begin
					$error("result with nothing expected: kind %0b byte %02h found %0b",
						result_kind, value_byte, key_found);
					mismatches++;
				end else begin
					want = extract_due.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0b, got %0b", want.kind, result_kind);
						mismatches++;
					end
					if (value_byte !== want.vbyte) begin
						$error("value_byte: expected %02h, got %02h", want.vbyte, value_byte);
						mismatches++;
					end
					if (key_found !== want.found) begin
						$error("key_found: expected %0b, got %0b", want.found, key_found);
						mismatches++;
					end
				end
			end
			results_due <= extract_due.size();
		end
	end

endmodule

/* sim/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fjkv_pkg::*;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [7:0]               doc_byte;
	logic                     doc_end;
	logic                     out_valid;
	logic                     out_stall;
	logic                     result_kind;
	logic [7:0]               value_byte;
	logic                     key_found;
	int                       mismatches;
	int                       results_due;

	bit         calm;
	bit         hold_out;
	logic [7:0] key_text [MAX_KEY_BYTES];
	int         key_used;
	logic [7:0] doc_q [$];

	flat_json_key_value_extractor u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.doc_byte    (doc_byte),
		.doc_end     (doc_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value_byte  (value_byte),
		.key_found   (key_found)
	);

	fjkv_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.doc_byte    (doc_byte),
		.doc_end     (doc_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value_byte  (value_byte),
		.key_found   (key_found),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500_000;
		$display("flat_json_key_value_extractor regression: fail");
		$finish;
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				out_stall <= 1'b0;
				hold_out = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [7:0] plain_pick();
		logic [7:0] c;
		c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom);
		if (c == CH_QUOTE || c == CH_BSLASH)
			c = 8'h5F;
		return c;
	endfunction

	function automatic logic [7:0] escape_pick();
		case ($urandom_range(0, 5))
			0:       return CH_N;
			1:       return CH_T;
			2:       return CH_R;
			3:       return CH_QUOTE;
			4:       return CH_BSLASH;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int text_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic program_key(input int len_reg);
		logic [CFG_DATA_BITS-1:0] word [KEY_REGS];
		foreach (word[w])
			for (int b = 0; b < 8; b++)
				word[w][b*8 +: 8] = key_text[w*8 + b];
		write_reg(REG_KEY_LENGTH, CFG_DATA_BITS'(len_reg));
		write_reg(REG_KEY_LOW, word[0]);
		write_reg(REG_KEY_MID, word[1]);
		write_reg(REG_KEY_HIGH, word[2]);
		write_reg(REG_KEY_TOP, word[3]);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_BITS'(REG_KEY_TOP + 1 + $urandom_range(0, 2)),
				{$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	task automatic make_key(input int len, input bit broken);
		int i;
		foreach (key_text[j])
			key_text[j] = 8'($urandom);
		i = 0;
		while (i < len) begin
			if (i + 1 < len && $urandom_range(0, 4) == 0) begin
				key_text[i]     = CH_BSLASH;
				key_text[i + 1] = escape_pick();
				i += 2;
			end else begin
				key_text[i] = plain_pick();
				i++;
			end
		end
		if (broken && len > 0) begin
			if ($urandom_range(0, 1))
				key_text[$urandom_range(0, len - 1)] = CH_QUOTE;
			else
				key_text[len - 1] = CH_BSLASH;
		end
		key_used = len;
	endtask

	task automatic add_byte(input logic [7:0] b);
		doc_q.insert(doc_q.size(), b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_ws();
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 5))
				0:       add_byte(CH_SPACE);
				1:       add_byte(CH_TAB);
				2:       add_byte(CH_LF);
				3:       add_byte(8'h0B);
				4:       add_byte(8'h0C);
				default: add_byte(CH_CR);
			endcase
		end
	endtask

	task automatic add_key();
		add_byte(CH_QUOTE);
		for (int i = 0; i < key_used; i++)
			add_byte(key_text[i]);
		add_byte(CH_QUOTE);
	endtask

	task automatic add_string(input int n);
		add_byte(CH_QUOTE);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				add_byte(CH_BSLASH);
				add_byte(escape_pick());
			end else begin
				add_byte(plain_pick());
			end
		end
		add_byte(CH_QUOTE);
	endtask

	task automatic add_value();
		case ($urandom_range(0, 6))
			0, 1, 2: add_string(text_len());
			3:       add_str("-12.5e3");
			4:       add_str("true");
			5:       add_str("{\"x\":[1,{}]}");
			default: add_str("[null,\"s\",2]");
		endcase
	endtask

	task automatic build_doc();
		int         members;
		int         cut;
		int         k;
		logic [7:0] t [$];
		doc_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24)) begin
				case ($urandom_range(0, 8))
					0:       add_byte(CH_LBRACE);
					1:       add_byte(CH_RBRACE);
					2:       add_byte(CH_LBRACK);
					3:       add_byte(CH_RBRACK);
					4:       add_byte(CH_QUOTE);
					5:       add_byte(CH_BSLASH);
					6:       add_byte(CH_COLON);
					7:       add_byte(key_text[$urandom_range(0, MAX_KEY_BYTES - 1)]);
					default: add_byte(8'($urandom));
				endcase
			end
		end else begin
			add_ws();
			add_byte(CH_LBRACE);
			members = $urandom_range(1, 4);
			for (int m = 0; m < members; m++) begin
				if (m > 0) begin
					add_str(",");
					add_ws();
				end
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						add_key();
						add_ws();
						add_byte(CH_COLON);
						add_ws();
						add_string(text_len());
					end
					3: begin
						add_key();
						add_ws();
						add_byte(CH_COLON);
						add_ws();
						add_value();
					end
					4: begin
						// key with no colon after it
						add_key();
						add_ws();
						case ($urandom_range(0, 2))
							0:       add_str(",");
							1:       add_byte(CH_RBRACE);
							default: add_byte(CH_LBRACE);
						endcase
					end
					5: begin
						t.delete();
						for (int i = 0; i < key_used; i++)
							t.insert(t.size(), key_text[i]);
						case ($urandom_range(0, 2))
							0: begin
								if (t.size() > 0)
									void'(t.pop_back());
								else
									t.insert(t.size(), 8'h71);
							end
							1: t.insert(t.size(), 8'h71);
							default: begin
								if (t.size() > 0) begin
									k = $urandom_range(0, t.size() - 1);
									t[k] = t[k] ^ 8'h01;
								end else begin
									t.insert(t.size(), 8'h7A);
								end
							end
						endcase
						add_byte(CH_QUOTE);
						foreach (t[i])
							add_byte(t[i]);
						add_byte(CH_QUOTE);
						add_byte(CH_COLON);
						add_string(text_len());
					end
					6: begin
						add_str("\"in\":");
						if ($urandom_range(0, 1)) begin
							add_byte(CH_LBRACE);
							add_key();
							add_byte(CH_COLON);
							add_string(text_len());
							add_byte(CH_RBRACE);
						end else begin
							add_byte(CH_LBRACK);
							add_key();
							add_str(",");
							add_string(text_len());
							add_byte(CH_RBRACK);
						end
					end
					default: begin
						add_byte(CH_QUOTE);
						repeat ($urandom_range(1, 4))
							add_byte(8'($urandom_range(8'h61, 8'h7A)));
						add_byte(CH_QUOTE);
						add_ws();
						add_byte(CH_COLON);
						add_ws();
						add_value();
					end
				endcase
			end
			add_ws();
			add_byte(CH_RBRACE);
			if ($urandom_range(0, 7) == 0) begin
				cut = $urandom_range(1, doc_q.size());
				while (doc_q.size() > cut)
					void'(doc_q.pop_back());
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		doc_byte <= b;
		doc_end  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_doc();
		foreach (doc_q[i])
			send_byte(doc_q[i], i == doc_q.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		int len;
		int sent;
		bit broken;
		arst_n = 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_KEY_LENGTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		doc_byte  <= 8'h00;
		doc_end   <= 1'b0;
		calm      = 1'b0;
		hold_out  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		make_key(1, 1'b0);
		key_text[0] = 8'h61;
		program_key(1);
		doc_q.delete();
		add_str("]{\"a\" :\t\"\\n\\t\\r\\\"");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_str("\"}");
		send_doc();
		doc_q.delete();
		add_str("{\"a\":\"\\");
		send_doc();
		drain();

		for (int p = 0; p < 12; p++) begin
			calm   = (p >= 10);
			broken = (p == 3) || (p > 4 && $urandom_range(0, 9) == 0);
			case (p)
				0:       len = 0;
				1, 2:    len = MAX_KEY_BYTES;
				default: len = ($urandom_range(0, 4) == 0) ?
					$urandom_range(13, MAX_KEY_BYTES) : $urandom_range(1, 12);
			endcase
			make_key(len, broken);
			program_key((p == 2) ?
				$urandom_range(MAX_KEY_BYTES + 1, (1 << KEY_LEN_BITS) - 1) : len);
			if (p == 4) begin
				// hold the output so the block backs up on a long value
				hold_out = 1'b1;
				doc_q.delete();
				add_byte(CH_LBRACE);
				add_key();
				add_byte(CH_COLON);
				add_string(40);
				add_byte(CH_RBRACE);
				send_doc();
			end
			sent = 0;
			while (sent < 85) begin
				build_doc();
				send_doc();
				sent += doc_q.size();
				if ($urandom_range(0, 9) == 0)
					drain();
			end
			drain();
		end

		// nest deep, then walk back down to one
		make_key(1, 1'b0);
		key_text[0] = 8'h6B;
		program_key(1);
		repeat (20)
			send_byte(CH_LBRACE, 1'b0);
		repeat (19)
			send_byte(CH_RBRACE, 1'b0);
		doc_q.delete();
		add_str("\"k\":\"v\"}");
		send_doc();
		drain();

		if (mismatches == 0 && results_due == 0)
			$display("flat_json_key_value_extractor regression: pass");
		else
			$display("flat_json_key_value_extractor regression: fail");
		$finish;
	end

endmodule
